>>> design/microcode_image_validator_assert.svh
// Assertion macros for the microcode image validator.
// Included by the top level; depends on nothing else.
// Each macro takes a label, the clock, the active-low reset, two terms and a message.
`ifndef MICROCODE_IMAGE_VALIDATOR_ASSERT_SVH
`define MICROCODE_IMAGE_VALIDATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MCV_ASSERT_IMPL(name, clk, rst_n, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication.
`define MCV_ASSERT_NEXT(name, clk, rst_n, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define MCV_ASSERT_IMPL(name, clk, rst_n, cond, prop, msg)
`define MCV_ASSERT_NEXT(name, clk, rst_n, cond, prop, msg)
`endif
`endif

>>> design/mcv_pkg.sv
// Shared types and constants of the microcode image validator.
// Used by mcv_stream, mcv_verdict and microcode_image_validator; depends on nothing.
`timescale 1ns / 1ps

package mcv_pkg;

	// Header layout, in 32-bit words.
	localparam int HDR_WORDS = 12;
	localparam logic [3:0] HW_HDRVER    = 4'd0;
	localparam logic [3:0] HW_REV       = 4'd1;
	localparam logic [3:0] HW_DATE      = 4'd2;
	localparam logic [3:0] HW_SIG       = 4'd3;
	localparam logic [3:0] HW_CKSUM     = 4'd4;
	localparam logic [3:0] HW_LOADER    = 4'd5;
	localparam logic [3:0] HW_PF        = 4'd6;
	localparam logic [3:0] HW_DSIZE     = 4'd7;
	localparam logic [3:0] HW_TSIZE     = 4'd8;
	localparam logic [3:0] HW_RESERVED0 = 4'd9;

	// Only version 1 is accepted for header and loader.
	localparam logic [31:0] SUPPORTED_VERSION = 32'd1;
	localparam logic [31:0] HDR_BYTES = 32'd48;
	localparam logic [31:0] EXT_HDR_BYTES = 32'd20;

	// Extended table: offset of the first entry and the word roles within an entry.
	localparam logic [2:0] EXT_COUNT_POS = 3'd0;
	localparam logic [2:0] EXT_ENTRY_POS = 3'd5;
	localparam logic [1:0] ENT_SIG   = 2'd0;
	localparam logic [1:0] ENT_PF    = 2'd1;
	localparam logic [1:0] ENT_CKSUM = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_SIGNATURE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_PLATFORM_FLAGS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_REVISION = 2'd2;

	typedef enum logic [2:0] {
		ST_OK,
		ST_VERSION,
		ST_SIZE,
		ST_EXT_COUNT,
		ST_EXT_SUM,
		ST_MAIN_SUM,
		ST_EXT_SIG_SUM,
		ST_LENGTH
	} status_t;

	typedef struct packed {
		logic [31:0] cpu_signature;
		logic [7:0]  cpu_platform_flags;
		logic [31:0] cpu_revision;
	} cfg_t;

	typedef struct packed {
		logic [31:0] image_word;
		logic        last_word;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        matches_cpu;
		logic [31:0] image_revision;
	} out_t;

	// Per-image state; the word counter travels separately as its width is a parameter.
	typedef struct packed {
		logic [31:0] rev;
		logic [31:0] sig;
		logic [31:0] dsize;
		logic [31:0] tsize;
		logic [31:0] extcnt;
		logic [30:0] mw;
		logic [31:0] ext_bytes;
		logic [29:0] ts_words;
		logic        size_bad;
		logic [31:0] main_sum;
		logic [31:0] ext_sum;
		logic [31:0] ent_sum;
		logic [31:0] ent_sig;
		logic [31:0] diff;
		logic        ver_err;
		logic        ent_err;
		logic        match;
		logic [2:0]  epos;
		logic [1:0]  kph;
	} stream_state_t;

endpackage

>>> design/mcv_stream.sv
// Per-word state of the microcode image validator: header capture, sums and signature matches.
// Depends on mcv_pkg.
`timescale 1ns / 1ps

module mcv_stream #(
	parameter int MAX_IMAGE_WORDS = 65536,
	parameter int DEFAULT_DATA_BYTES = 2000,
	localparam int IDX_W = $clog2(MAX_IMAGE_WORDS + 2)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   word_en,
	input  logic                   clear,
	input  mcv_pkg::in_t           req,
	input  mcv_pkg::cfg_t          cfg,
	output logic [IDX_W-1:0]       idx,
	output mcv_pkg::stream_state_t state
);

	localparam logic [IDX_W-1:0] IDX_SAT = IDX_W'(MAX_IMAGE_WORDS + 1);
	localparam logic [33:0] MAX_BYTES = 34'(MAX_IMAGE_WORDS) << 2;
	localparam logic [31:0] DEF_DATA = 32'(DEFAULT_DATA_BYTES);
	localparam logic [31:0] DEF_TOTAL = 32'(DEFAULT_DATA_BYTES + 48);

	logic [IDX_W-1:0]       idx_q, cur_idx, nxt_idx;
	mcv_pkg::stream_state_t st_q, cur, nxt;
	logic [31:0]            w, ds_eff, ts_eff, entry_total;
	logic                   hdr, in_ext;

	// A signature matches when it names this processor on its platform with a newer revision.
	function automatic logic sig_match(input logic [31:0] s, input logic [31:0] pf,
			input logic [31:0] rev, input mcv_pkg::cfg_t c);
		logic pf_ok;
		pf_ok = ((pf & {24'b0, c.cpu_platform_flags}) != 32'b0) ||
			(pf == 32'b0 && c.cpu_platform_flags == 8'b0);
		return (s == c.cpu_signature) && pf_ok && (rev > c.cpu_revision);
	endfunction

	// Next state for one word; a finishing image is seen as already cleared.
	always_comb begin
		cur_idx = clear ? '0 : idx_q;
		cur = clear ? '0 : st_q;
		nxt_idx = cur_idx;
		nxt = cur;
		w = req.image_word;
		hdr = cur_idx < IDX_W'(mcv_pkg::HDR_WORDS);
		in_ext = !hdr && (31'(cur_idx) >= cur.mw);
		ds_eff = (cur.dsize == 32'b0) ? DEF_DATA : cur.dsize;
		ts_eff = (cur.tsize == 32'b0) ? DEF_TOTAL : cur.tsize;
		entry_total = cur.ent_sum + w;
		if (word_en) begin
			if (!in_ext) begin
				nxt.main_sum = cur.main_sum + w;
				// The running difference leaves out the words that make up the header check sum.
				if (!(hdr && (cur_idx[3:0] == mcv_pkg::HW_SIG ||
						cur_idx[3:0] == mcv_pkg::HW_CKSUM ||
						cur_idx[3:0] == mcv_pkg::HW_PF))) begin
					nxt.diff = cur.diff + w;
				end
			end else begin
				nxt.ext_sum = cur.ext_sum + w;
			end

			// Header fields.
			if (hdr) begin
				case (cur_idx[3:0])
					mcv_pkg::HW_HDRVER, mcv_pkg::HW_LOADER: begin
						if (w != mcv_pkg::SUPPORTED_VERSION) begin
							nxt.ver_err = 1'b1;
						end
					end
					mcv_pkg::HW_REV: begin
						nxt.rev = w;
					end
					mcv_pkg::HW_SIG: begin
						nxt.sig = w;
					end
					mcv_pkg::HW_PF: begin
						if (sig_match(cur.sig, w, cur.rev, cfg)) begin
							nxt.match = 1'b1;
						end
					end
					mcv_pkg::HW_DSIZE: begin
						nxt.dsize = w;
					end
					mcv_pkg::HW_TSIZE: begin
						nxt.tsize = w;
						nxt.mw = 31'(mcv_pkg::HDR_WORDS) + 31'(ds_eff[31:2]);
					end
					mcv_pkg::HW_RESERVED0: begin
						// Both sizes are known now; settle the size checks early.
						nxt.size_bad = ({2'b0, ds_eff} + 34'(mcv_pkg::HDR_BYTES) >
							{2'b0, ts_eff}) || (ds_eff[1:0] != 2'b0) ||
							(ts_eff[1:0] != 2'b0) || ({2'b0, ts_eff} > MAX_BYTES);
						nxt.ext_bytes = ts_eff - mcv_pkg::HDR_BYTES - ds_eff;
						nxt.ts_words = ts_eff[31:2];
					end
					default: begin
					end
				endcase
			end

			// Extended signature table.
			if (in_ext) begin
				if (cur.epos != mcv_pkg::EXT_ENTRY_POS) begin
					if (cur.epos == mcv_pkg::EXT_COUNT_POS) begin
						nxt.extcnt = w;
					end
				end else begin
					case (cur.kph)
						mcv_pkg::ENT_SIG: begin
							nxt.ent_sig = w;
							nxt.ent_sum = w;
						end
						mcv_pkg::ENT_PF: begin
							nxt.ent_sum = entry_total;
							if (sig_match(cur.ent_sig, w, cur.rev, cfg)) begin
								nxt.match = 1'b1;
							end
						end
						mcv_pkg::ENT_CKSUM: begin
							nxt.ent_sum = entry_total;
							if (cur.diff + entry_total != 32'b0) begin
								nxt.ent_err = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				// Table position moves only with the word counter.
				if (cur_idx != IDX_SAT) begin
					if (cur.epos != mcv_pkg::EXT_ENTRY_POS) begin
						nxt.epos = cur.epos + 3'd1;
					end else if (cur.kph == mcv_pkg::ENT_CKSUM) begin
						nxt.kph = mcv_pkg::ENT_SIG;
					end else begin
						nxt.kph = cur.kph + 2'd1;
					end
				end
			end

			// Saturating word counter.
			if (cur_idx != IDX_SAT) begin
				nxt_idx = cur_idx + 1'b1;
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			st_q <= '0;
		end else begin
			idx_q <= nxt_idx;
			st_q <= nxt;
		end
	end

	assign idx = idx_q;
	assign state = st_q;

endmodule

>>> design/mcv_verdict.sv
// Final status of a finished image, from the stream state in priority order.
// Depends on mcv_pkg.
`timescale 1ns / 1ps

module mcv_verdict #(
	parameter int IDX_W = 17
) (
	input  logic [IDX_W-1:0]       idx,
	input  mcv_pkg::stream_state_t state,
	output mcv_pkg::out_t          rsp
);

	mcv_pkg::status_t status;
	logic [31:0]      ext_m20;
	logic [35:0]      cnt_bytes;
	logic             ext_nz, shape_bad;

	// Residue modulo 3 by summing base-4 digits, as 4 is 1 modulo 3.
	function automatic logic [1:0] mod3(input logic [29:0] x);
		logic [5:0] s;
		logic [3:0] t;
		s = '0;
		for (int i = 0; i < 15; i++) begin
			s = s + 6'(x[2*i +: 2]);
		end
		t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
		if (t >= 4'd6) begin
			t = t - 4'd6;
		end else if (t >= 4'd3) begin
			t = t - 4'd3;
		end
		return t[1:0];
	endfunction

	// Table shape and count checks.
	always_comb begin
		ext_nz = state.ext_bytes != 32'b0;
		ext_m20 = state.ext_bytes - mcv_pkg::EXT_HDR_BYTES;
		shape_bad = ext_nz && ((state.ext_bytes < mcv_pkg::EXT_HDR_BYTES) ||
			(ext_m20[1:0] != 2'b0) || (mod3(ext_m20[31:2]) != 2'd0));
		cnt_bytes = {1'b0, state.extcnt, 3'b0} + {2'b0, state.extcnt, 2'b0} +
			36'(mcv_pkg::EXT_HDR_BYTES);
	end

	// First failing check gives the status.
	always_comb begin
		if (idx < IDX_W'(mcv_pkg::HDR_WORDS)) begin
			status = mcv_pkg::ST_LENGTH;
		end else if (state.size_bad) begin
			status = mcv_pkg::ST_SIZE;
		end else if (state.ver_err) begin
			status = mcv_pkg::ST_VERSION;
		end else if (shape_bad) begin
			status = mcv_pkg::ST_SIZE;
		end else if (30'(idx) != state.ts_words) begin
			status = mcv_pkg::ST_LENGTH;
		end else if (ext_nz && cnt_bytes != 36'(state.ext_bytes)) begin
			status = mcv_pkg::ST_EXT_COUNT;
		end else if (ext_nz && state.ext_sum != 32'b0) begin
			status = mcv_pkg::ST_EXT_SUM;
		end else if (state.main_sum != 32'b0) begin
			status = mcv_pkg::ST_MAIN_SUM;
		end else if (ext_nz && state.ent_err) begin
			status = mcv_pkg::ST_EXT_SIG_SUM;
		end else begin
			status = mcv_pkg::ST_OK;
		end
	end

	assign rsp.status = status;
	assign rsp.matches_cpu = (status == mcv_pkg::ST_OK) && state.match;
	assign rsp.image_revision = state.rev;

endmodule

>>> design/microcode_image_validator.sv
// Top level of the microcode image validator: handshakes, configuration and result register.
// Depends on mcv_pkg, mcv_stream, mcv_verdict and microcode_image_validator_assert.svh.
`timescale 1ns / 1ps

// The validator takes one 32-bit image word per cycle, back to back, while image_stall is
// low, and gives one result for each word marked last. Each word is held in an input
// register, then folded into the image state by a single add-and-compare step; the result
// register is loaded from the finished image's verdict once it is free, and the first word
// of the next image may follow the last word of the previous one directly. While a result
// waits to be taken the finished image's state is held, and at most one further word is
// taken into the input register before image_stall rises. Write the configuration only
// while no image is in flight; it is sampled as each platform-flags word is processed.

`include "microcode_image_validator_assert.svh"

module microcode_image_validator #(
	parameter int MAX_IMAGE_WORDS = 65536,
	parameter int DEFAULT_DATA_BYTES = 2000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                image_valid,
	output logic                                image_stall,
	input  mcv_pkg::in_t                        image_req,
	output logic                                result_valid,
	input  logic                                result_stall,
	output mcv_pkg::out_t                       result_rsp,
	input  logic                                cfg_write,
	input  logic [mcv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mcv_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(MAX_IMAGE_WORDS + 2);

	mcv_pkg::cfg_t          cfg_q;
	mcv_pkg::in_t           req_s1;
	logic                   valid_s1;
	logic                   fin_q;
	logic                   result_valid_q;
	mcv_pkg::out_t          result_q;
	mcv_pkg::out_t          verdict;
	mcv_pkg::stream_state_t stream_state;
	logic [IDX_W-1:0]       stream_idx;
	logic                   adv_fin, clear, do_word, accept;

	// Flow control: a finished image leaves when the result register is free.
	assign adv_fin = !result_valid_q || !result_stall;
	assign clear = fin_q && adv_fin;
	assign do_word = valid_s1 && (!fin_q || adv_fin);
	assign image_stall = valid_s1 && !do_word;
	assign accept = image_valid && !image_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				mcv_pkg::CFG_CPU_SIGNATURE: begin
					cfg_q.cpu_signature <= cfg_data;
				end
				mcv_pkg::CFG_CPU_PLATFORM_FLAGS: begin
					cfg_q.cpu_platform_flags <= cfg_data[7:0];
				end
				mcv_pkg::CFG_CPU_REVISION: begin
					cfg_q.cpu_revision <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (do_word) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= image_req;
		end
	end

	// Marks an image whose last word has been folded in and awaits its verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else if (do_word && req_s1.last_word) begin
			fin_q <= 1'b1;
		end else if (clear) begin
			fin_q <= 1'b0;
		end
	end

	mcv_stream #(
		.MAX_IMAGE_WORDS    (MAX_IMAGE_WORDS),
		.DEFAULT_DATA_BYTES (DEFAULT_DATA_BYTES)
	) u_stream (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_en (do_word),
		.clear   (clear),
		.req     (req_s1),
		.cfg     (cfg_q),
		.idx     (stream_idx),
		.state   (stream_state)
	);

	mcv_verdict #(
		.IDX_W (IDX_W)
	) u_verdict (
		.idx   (stream_idx),
		.state (stream_state),
		.rsp   (verdict)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (clear) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			result_q <= verdict;
		end
	end

	assign result_valid = result_valid_q;
	assign result_rsp = result_q;

	// A processed last word always leaves an image waiting for its verdict.
	`MCV_ASSERT_NEXT(a_fin_after_last, clk, arst_n, do_word && req_s1.last_word, fin_q, "last word did not finish the image")
	// A match is only reported for a clean image.
	`MCV_ASSERT_IMPL(a_match_needs_ok, clk, arst_n, result_valid_q && result_q.matches_cpu, result_q.status == mcv_pkg::ST_OK, "match reported with a failing status")
	// Every new result comes from a finished image.
	`MCV_ASSERT_IMPL(a_result_from_fin, clk, arst_n, $rose(result_valid_q), $past(fin_q), "result appeared without a finished image")
	// An image shorter than its header is a length fault.
	`MCV_ASSERT_NEXT(a_short_image, clk, arst_n, clear && (stream_idx < IDX_W'(mcv_pkg::HDR_WORDS)), result_q.status == mcv_pkg::ST_LENGTH, "short image not reported as a length fault")

endmodule
